// ===== rtl/act_pkg.sv =====
// Shared types and codes for the cook-timer controller.
package act_pkg;

    // Event codes carried on the input tuser
    localparam logic [2:0] KIND_DIGIT = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_PAUSE = 3'd3;
    localparam logic [2:0] KIND_SLEEP = 3'd4;
    localparam logic [2:0] KIND_TICK  = 3'd5;
    localparam logic [2:0] KIND_POLL  = 3'd6;

    // Run modes
    localparam logic [1:0] MODE_STOPPED  = 2'd0;
    localparam logic [1:0] MODE_COOKING  = 2'd1;
    localparam logic [1:0] MODE_PAUSED   = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    // LED bits
    localparam logic [1:0] LIGHT_NONE = 2'b00;
    localparam logic [1:0] LIGHT_COOK = 2'b01;
    localparam logic [1:0] LIGHT_STOP = 2'b10;

    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [1:0] ENTRY_MAX    = 2'd2;
    localparam logic [6:0] ELAPSED_MAX  = 7'd127;
    localparam logic [8:0] TEMP_LIMIT_RESET = 9'd100;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Controller state
    typedef struct packed {
        logic [1:0] run_mode;
        logic       sleeping;
        logic [1:0] entry_count;
        logic [3:0] digit0;
        logic [3:0] digit1;
        logic [6:0] target_min;
        logic [6:0] elapsed_min;
        logic [6:0] remaining_min;
        logic [6:0] held_min;
        logic [8:0] last_temp;
        logic [1:0] lights;
    } act_state_t;

    localparam act_state_t STATE_RESET = '{
        run_mode:      MODE_STOPPED,
        sleeping:      1'b1,
        entry_count:   2'd0,
        digit0:        4'd0,
        digit1:        4'd0,
        target_min:    7'd0,
        elapsed_min:   7'd0,
        remaining_min: 7'd0,
        held_min:      7'd0,
        last_temp:     9'd0,
        lights:        LIGHT_NONE
    };

endpackage

// ===== rtl/appliance_cook_timer_fsm_top.sv =====
// Top level of the cook-timer controller: stream ports, input and result registers.
//
// Usage:
//   Each input transaction carries one event (s_tuser = event kind, s_tdata =
//   key digit and temperature). Every event produces exactly one result
//   transaction on the m_ side reporting mode, sleep flag, LEDs, minutes left
//   and digits entered after the event is applied.
//   The temperature limit is written on the cfg_ channel (cfg_ready is always
//   high); write it only while no event is in flight.
//   An accepted event is loaded into the input register and then applied into
//   the state and result registers.
//   Throughput: one event per cycle while results are taken; the state update
//   is a single short pass of logic from the input register into the state and
//   result registers. When the receiver stalls, the result register holds, the
//   input register fills, and s_tready drops until the result is taken.
//   Reset (aresetn low, synchronous) empties both registers, puts the
//   controller in stopped mode and asleep with LEDs off and all counts zero,
//   and sets the temperature limit to 100.
module appliance_cook_timer_fsm_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [act_pkg::IN_DATA_W-1:0]  s_tdata,  // [3:0] key_digit, [12:4] temperature,
                                                     // [15:13] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [act_pkg::OUT_DATA_W-1:0] m_tdata,  // [1:0] mode, [2] asleep,
                                                     // [3] cooking_light, [4] stop_light,
                                                     // [11:5] minutes_left,
                                                     // [13:12] digits_entered, [15:14] zero
    // Temperature limit write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import act_pkg::*;

    logic               in_valid_reg;
    logic [2:0]         in_kind_reg;
    logic [3:0]         in_digit_reg;
    logic [8:0]         in_temp_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [8:0]         max_temp_reg;
    act_state_t         state_reg;
    act_state_t         state_next;
    logic               advance;
    logic               in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    act_step u_step (
        .cur             (state_reg),
        .kind            (in_kind_reg),
        .key_digit       (in_digit_reg),
        .temperature     (in_temp_reg),
        .max_temperature (max_temp_reg),
        .nxt             (state_next)
    );

    // Hold the temperature limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_temp_reg <= TEMP_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_temp_reg <= cfg_data;
        end
    end

    // Capture an input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg  <= s_tuser;
            in_digit_reg <= s_tdata[3:0];
            in_temp_reg  <= s_tdata[12:4];
        end
    end

    // Apply the event and register the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, state_next.entry_count, state_next.remaining_min,
                             state_next.lights[1], state_next.lights[0],
                             state_next.sleeping, state_next.run_mode};
        end
    end

    // Empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // Asleep implies stopped with LEDs off
    a_sleep_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.sleeping |-> (state_reg.run_mode == MODE_STOPPED &&
                                state_reg.lights == LIGHT_NONE))
        else $error("asleep while running or lit");

    // No more than two digits held
    a_entry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.entry_count <= ENTRY_MAX)
        else $error("entry count out of range");

    // A processed event always yields a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed event produced no result");

endmodule

// ===== rtl/act_step.sv =====
// Next-state logic of the cook-timer controller for one event.
module act_step (
    input  act_pkg::act_state_t cur,
    input  logic [2:0]          kind,
    input  logic [3:0]          key_digit,
    input  logic [8:0]          temperature,
    input  logic [8:0]          max_temperature,
    output act_pkg::act_state_t nxt
);
    import act_pkg::*;

    logic       ready;
    logic [6:0] entry_value;
    logic [6:0] elapsed_inc;

    // Two-digit entry: tens * 10 + units, digits are at most 9
    assign entry_value = ({3'd0, cur.digit0} << 3) + ({3'd0, cur.digit0} << 1)
                       + {3'd0, cur.digit1};
    assign ready = (cur.run_mode == MODE_STOPPED) && !cur.sleeping;
    assign elapsed_inc = (cur.elapsed_min < ELAPSED_MAX) ? cur.elapsed_min + 7'd1
                                                         : cur.elapsed_min;

    always_comb begin
        nxt = cur;
        unique case (kind)
            KIND_DIGIT: begin
                if (ready && key_digit <= DIGIT_MAX && cur.entry_count < ENTRY_MAX) begin
                    if (cur.entry_count == 2'd0) begin
                        nxt.digit0 = key_digit;
                    end else begin
                        nxt.digit1 = key_digit;
                    end
                    nxt.entry_count = cur.entry_count + 2'd1;
                end
            end
            KIND_START: begin
                if (ready) begin
                    if (cur.entry_count == 2'd1) begin
                        nxt.target_min = {3'd0, cur.digit0};
                    end else if (cur.entry_count == 2'd2) begin
                        nxt.target_min = entry_value;
                    end
                    nxt.remaining_min = nxt.target_min;
                    if (nxt.target_min != 7'd0) begin
                        nxt.run_mode = MODE_COOKING;
                    end
                end else if (cur.run_mode == MODE_PAUSED && cur.target_min != 7'd0) begin
                    // Resume; nothing held means the run is already done
                    nxt.remaining_min = cur.held_min;
                    nxt.target_min    = cur.held_min;
                    nxt.run_mode      = (cur.held_min == 7'd0) ? MODE_FINISHED
                                                               : MODE_COOKING;
                end
            end
            KIND_STOP: begin
                if (!cur.sleeping) begin
                    nxt.run_mode    = MODE_STOPPED;
                    nxt.lights      = LIGHT_STOP;
                    nxt.elapsed_min = 7'd0;
                    nxt.target_min  = 7'd0;
                    nxt.entry_count = 2'd0;
                    nxt.digit0      = 4'd0;
                    nxt.digit1      = 4'd0;
                    nxt.held_min    = 7'd0;
                    nxt.last_temp   = 9'd0;
                end
            end
            KIND_PAUSE: begin
                if (!cur.sleeping && cur.run_mode != MODE_STOPPED) begin
                    nxt.lights      = LIGHT_STOP;
                    nxt.run_mode    = MODE_PAUSED;
                    nxt.held_min    = cur.remaining_min;
                    nxt.elapsed_min = 7'd0;
                end
            end
            KIND_SLEEP: begin
                if (cur.sleeping) begin
                    nxt.sleeping = 1'b0;
                    nxt.lights   = cur.lights | LIGHT_STOP;
                end else begin
                    nxt = STATE_RESET;
                    nxt.remaining_min = cur.remaining_min;
                end
            end
            KIND_TICK: begin
                if (cur.run_mode == MODE_COOKING) begin
                    nxt.elapsed_min = elapsed_inc;
                    if (cur.remaining_min != 7'd0) begin
                        nxt.remaining_min = cur.remaining_min - 7'd1;
                    end
                    if (elapsed_inc == cur.target_min) begin
                        nxt.run_mode = MODE_FINISHED;
                    end
                    nxt.last_temp = temperature;
                end
            end
            KIND_POLL: begin
                if (cur.run_mode == MODE_COOKING) begin
                    if (cur.last_temp > max_temperature) begin
                        // Overheat: drop into sleep, keep the display count
                        nxt = STATE_RESET;
                        nxt.remaining_min = cur.remaining_min;
                    end else begin
                        nxt.lights = LIGHT_COOK;
                    end
                end else if (cur.run_mode == MODE_FINISHED) begin
                    nxt.lights      = LIGHT_STOP;
                    nxt.run_mode    = MODE_STOPPED;
                    nxt.elapsed_min = 7'd0;
                    nxt.target_min  = 7'd0;
                    nxt.entry_count = 2'd0;
                    nxt.digit0      = 4'd0;
                    nxt.digit1      = 4'd0;
                    nxt.held_min    = 7'd0;
                    nxt.last_temp   = 9'd0;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cook-timer controller: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module testbench;
    import act_pkg::*;

    // Kind code with no defined event; the block must just report its state
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int STALL_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    // One result transaction, field by field
    typedef struct packed {
        logic [1:0] mode;
        logic       asleep;
        logic       cook_light;
        logic       stop_light;
        logic [6:0] minutes_left;
        logic [1:0] digits_entered;
    } panel_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [3:0] key_digit, [12:4] temperature, [15:13] zero
    logic [2:0]  s_tuser   = '0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [1:0] mode, [2] asleep, [3] cooking_light,
                                   // [4] stop_light, [11:5] minutes_left,
                                   // [13:12] digits_entered, [15:14] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data  = '0;

    appliance_cook_timer_fsm_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predicted controller state and temperature limit
    logic [1:0] p_mode;
    logic       p_asleep;
    logic [1:0] p_count;
    logic [3:0] p_digit [2];
    logic [6:0] p_target, p_elapsed, p_remaining, p_held;
    logic [8:0] p_last_temp, p_limit;
    logic [1:0] p_lights;

    panel_t expected_status [$];
    int     items_sent     = 0;
    int     results_seen   = 0;
    int     fault_count    = 0;
    int     limits_written = 0;
    int     cycle_count    = 0;
    bit     tx_gaps_on     = 1'b0;
    bit     rx_gaps_on     = 1'b0;
    bit     stall_go       = 1'b0;
    bit     stall_seen     = 1'b0;
    int     stall_left     = 0;
    int     rx_gap_left    = 0;

    function automatic void clear_counts();
        p_elapsed   = '0;
        p_target    = '0;
        p_count     = '0;
        p_digit[0]  = '0;
        p_digit[1]  = '0;
        p_held      = '0;
        p_last_temp = '0;
    endfunction

    function automatic void go_to_sleep();
        p_lights = LIGHT_NONE;
        p_mode   = MODE_STOPPED;
        clear_counts();
        p_asleep = 1'b1;
    endfunction

    function automatic void cook_timer_reset();
        p_limit     = TEMP_LIMIT_RESET;
        p_mode      = MODE_STOPPED;
        p_asleep    = 1'b1;
        p_remaining = '0;
        p_lights    = LIGHT_NONE;
        clear_counts();
    endfunction

    // Apply one event to the predicted state and return the panel it shows
    function automatic panel_t cook_timer_next(logic [2:0] kind, logic [3:0] digit,
                                               logic [8:0] temp);
        panel_t r;
        logic   ready;
        ready = (p_mode == MODE_STOPPED) && !p_asleep;
        case (kind)
            KIND_DIGIT: begin
                if (ready && digit <= DIGIT_MAX && p_count < ENTRY_MAX) begin
                    if (p_count == 2'd0)
                        p_digit[0] = digit;
                    else
                        p_digit[1] = digit;
                    p_count = p_count + 2'd1;
                end
            end
            KIND_START: begin
                if (ready) begin
                    if (p_count == 2'd1)
                        p_target = {3'b000, p_digit[0]};
                    else if (p_count == 2'd2)
                        p_target = p_digit[0] * 7'd10 + p_digit[1];
                    p_remaining = p_target;
                    if (p_target != 0)
                        p_mode = MODE_COOKING;
                end else if (p_mode == MODE_PAUSED && p_target != 0) begin
                    p_remaining = p_held;
                    p_target    = p_held;
                    p_mode      = (p_held == 0) ? MODE_FINISHED : MODE_COOKING;
                end
            end
            KIND_STOP: begin
                if (!p_asleep) begin
                    p_mode   = MODE_STOPPED;
                    p_lights = LIGHT_STOP;
                    clear_counts();
                end
            end
            KIND_PAUSE: begin
                if (!p_asleep && p_mode != MODE_STOPPED) begin
                    p_lights  = LIGHT_STOP;
                    p_mode    = MODE_PAUSED;
                    p_held    = p_remaining;
                    p_elapsed = '0;
                end
            end
            KIND_SLEEP: begin
                if (p_asleep) begin
                    p_asleep = 1'b0;
                    p_lights = p_lights | LIGHT_STOP;
                end else begin
                    go_to_sleep();
                end
            end
            KIND_TICK: begin
                if (p_mode == MODE_COOKING) begin
                    if (p_elapsed < ELAPSED_MAX)
                        p_elapsed = p_elapsed + 7'd1;
                    if (p_remaining > 0)
                        p_remaining = p_remaining - 7'd1;
                    if (p_elapsed == p_target)
                        p_mode = MODE_FINISHED;
                    p_last_temp = temp;
                end
            end
            KIND_POLL: begin
                if (p_mode == MODE_COOKING) begin
                    p_lights = LIGHT_COOK;
                    if (p_last_temp > p_limit)
                        go_to_sleep();
                end else if (p_mode == MODE_FINISHED) begin
                    p_lights = LIGHT_STOP;
                    clear_counts();
                    p_mode = MODE_STOPPED;
                end
            end
            default: ;
        endcase
        r.mode           = p_mode;
        r.asleep         = p_asleep;
        r.cook_light     = p_lights[0];
        r.stop_light     = p_lights[1];
        r.minutes_left   = p_remaining;
        r.digits_entered = p_count;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("MISMATCH result %0d %s: expected %0d, got %0d",
                         results_seen, name, want, got);
        end
    endtask

    task automatic check_result(input logic [15:0] word);
        panel_t want;
        results_seen++;
        if (expected_status.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("MISMATCH result %0d arrived with nothing expected: %h",
                         results_seen, word);
        end else begin
            want = expected_status.pop_front();
            compare_field("mode", want.mode, word[1:0]);
            compare_field("asleep", want.asleep, word[2]);
            compare_field("cooking_light", want.cook_light, word[3]);
            compare_field("stop_light", want.stop_light, word[4]);
            compare_field("minutes_left", want.minutes_left, word[11:5]);
            compare_field("digits_entered", want.digits_entered, word[13:12]);
        end
    endtask

    // Result side: check each transaction, then choose the next ready value
    always @(posedge aclk) begin : result_side
        int gap;
        if (aresetn && m_tvalid && m_tready)
            check_result(m_tdata);
        if (stall_go != stall_seen) begin
            stall_seen <= stall_go;
            stall_left <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left <= rx_gap_left - 1;
            m_tready    <= 1'b0;
        end else begin
            gap = pick_gap(rx_gaps_on);
            if (gap != 0) begin
                rx_gap_left <= gap - 1;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one event, wait for its transaction, and record what it must produce
    task automatic send_event(input logic [2:0] kind, input logic [3:0] digit,
                              input logic [8:0] temp);
        int gap;
        gap = pick_gap(tx_gaps_on);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, temp, digit};
        do @(posedge aclk); while (!s_tready);
        expected_status.push_back(cook_timer_next(kind, digit, temp));
        items_sent++;
    endtask

    // Button press with the unused fields randomized
    task automatic press(input logic [2:0] kind);
        send_event(kind, 4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)));
    endtask

    // Hold the input idle until every expected result is in
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [8:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_limit = value;
        limits_written++;
    endtask

    // Short cook times mostly, some out-of-range keys
    function automatic logic [3:0] pick_digit(bit leading);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 4'($urandom_range(10, 15));
        if (leading && r < 75)
            return 4'd0;
        return 4'($urandom_range(0, 9));
    endfunction

    // Temperature mostly at or below the limit, sometimes anywhere
    function automatic logic [8:0] pick_temp();
        if ($urandom_range(0, 99) < 75)
            return 9'($urandom_range(0, p_limit));
        return 9'($urandom_range(0, 511));
    endfunction

    // One well-formed cooking run with random events along the way
    task automatic run_cook_cycle();
        int steps;
        int r;
        if (p_asleep)
            press(KIND_SLEEP);
        if (p_mode != MODE_STOPPED)
            press(KIND_STOP);
        send_event(KIND_DIGIT, pick_digit(1'b1), 9'($urandom_range(0, 511)));
        if ($urandom_range(0, 3) != 0)
            send_event(KIND_DIGIT, pick_digit(1'b0), 9'($urandom_range(0, 511)));
        press(KIND_START);
        steps = 0;
        while (p_mode != MODE_STOPPED && steps < 60) begin
            r = $urandom_range(0, 99);
            if (p_mode == MODE_PAUSED) begin
                if (r < 80) press(KIND_START);
                else if (r < 90) press(KIND_PAUSE);
                else press(KIND_STOP);
            end else if (p_mode == MODE_FINISHED) begin
                if (r < 20) press(KIND_PAUSE);
                else if (r < 30) press(KIND_TICK);
                else press(KIND_POLL);
            end else begin
                if (r < 60) send_event(KIND_TICK, 4'($urandom_range(0, 15)), pick_temp());
                else if (r < 85) press(KIND_POLL);
                else if (r < 92) press(KIND_PAUSE);
                else if (r < 96) press(KIND_SLEEP);
                else press(KIND_STOP);
            end
            steps++;
        end
    endtask

    task automatic cook_for(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
            run_cook_cycle();
    endtask

    // Corner events from reset: asleep buttons, key limits, a short run, keys while asleep
    task automatic test_directed();
        send_event(KIND_DIGIT, 4'd5, 9'd0);
        press(KIND_START);
        press(KIND_STOP);
        press(KIND_PAUSE);
        send_event(KIND_TICK, 4'd0, 9'd511);
        press(KIND_POLL);
        press(KIND_SLEEP);
        press(KIND_PAUSE);
        press(KIND_START);
        send_event(KIND_DIGIT, 4'd15, 9'd0);
        send_event(KIND_DIGIT, 4'd0, 9'd0);
        send_event(KIND_DIGIT, 4'd9, 9'd511);
        send_event(KIND_DIGIT, 4'd3, 9'd0);
        press(KIND_START);
        send_event(KIND_TICK, 4'd0, 9'd0);
        send_event(KIND_TICK, 4'd15, 9'd511);
        press(KIND_POLL);
        press(KIND_UNUSED);
        press(KIND_SLEEP);
        send_event(KIND_DIGIT, 4'd1, 9'd0);
        press(KIND_START);
        send_event(KIND_TICK, 4'd0, 9'd50);
        press(KIND_PAUSE);
        press(KIND_START);
        press(KIND_POLL);
    endtask

    // Limit at both ends: never too hot, then hot at any nonzero sample
    task automatic test_limit_extremes();
        tx_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;
        write_limit(9'd511);
        cook_for(175);
        write_limit(9'd0);
        cook_for(175);
    endtask

    // Random runs under several limits, first phase with no idling at all
    task automatic test_cook_sequences();
        for (int phase = 0; phase < 4; phase++) begin
            tx_gaps_on = (phase != 0);
            rx_gaps_on <= (phase != 0);
            write_limit(9'($urandom_range(0, 511)));
            cook_for(250);
        end
    endtask

    // Long receiver hold-off while events keep coming back to back
    task automatic test_backpressure();
        settle();
        tx_gaps_on = 1'b0;
        stall_go <= ~stall_go;
        cook_for(40);
        tx_gaps_on = 1'b1;
    endtask

    // Unstructured events of every kind, including the unused code
    task automatic test_noise();
        write_limit(9'($urandom_range(0, 511)));
        repeat (350)
            send_event(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                       9'($urandom_range(0, 511)));
    endtask

    initial begin
        cook_timer_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limit_extremes();
        test_cook_sequences();
        test_backpressure();
        test_noise();
        settle();
        repeat (8) @(posedge aclk);
        $display("Covered %0d events and %0d results under %0d temperature limits,",
                 items_sent, results_seen, limits_written);
        $display("with random idling on both sides and one long receiver stall.");
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
